// ===== src/hearing_mix_soft_knee_limiter_top_macros.svh =====
// assertion macros shared by the rtl
`ifndef HEARING_MIX_SOFT_KNEE_LIMITER_TOP_MACROS_SVH
`define HEARING_MIX_SOFT_KNEE_LIMITER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HMSKL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hmskl assertion failed");
`define HMSKL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hmskl assertion failed");
`else
`define HMSKL_ASSERT(name, clk, rst_n, prop)
`define HMSKL_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/hmskl_pkg.sv =====
package hmskl_pkg;

  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_N_W = 28;
  localparam int unsigned DIV_D_W = 16;

  localparam logic [15:0] HP_POLE      = 16'd31130;
  localparam logic [15:0] ATTACK_COEF  = 16'd655;
  localparam logic [15:0] RELEASE_COEF = 16'd6554;
  localparam logic [23:0] KNEE_LO      = 24'd22938;
  localparam logic [23:0] KNEE_HI      = 24'd29491;
  localparam logic [15:0] LIMIT_POS    = 16'sd26214;
  localparam logic [15:0] LIMIT_NEG    = -16'sd26214;
  localparam logic [23:0] ENV_MAX      = 24'hFFFFFF;
  localparam logic [15:0] MIC_GAIN_RST = 16'd4096;
  localparam logic [15:0] AMB_GAIN_RST = 16'd0;

  localparam logic [1:0] REG_MIC_GAIN = 2'd0;
  localparam logic [1:0] REG_AMB_GAIN = 2'd1;
  localparam logic [1:0] REG_NS_EN    = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HP_GO,
    ST_HP_WAIT,
    ST_MIX1_GO,
    ST_MIX1_WAIT,
    ST_MIX2_GO,
    ST_MIX2_WAIT,
    ST_ENV_GO,
    ST_ENV_WAIT,
    ST_KNEE_CHK,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_KM_GO,
    ST_KM_WAIT,
    ST_OUT
  } state_e;

endpackage

// ===== src/hearing_mix_soft_knee_limiter_top.sv =====
// channel | direction | payload       | handshake
// in      | input     | sample_in_i   | in_valid_i / in_stall_o
// out     | output    | sample_out_o  | out_valid_o / out_stall_i
// cfg     | input     | pwdata/prdata | apb psel / penable, pready always high
//
// a transaction outside the knee skips the knee steps, and the high-pass step runs
// only when it is enabled; the shared bit-serial multiplier and the 28-step
// divider do the arithmetic
// rst_ni clears the state machine, the filter and envelope state and the apb registers
// a stalled result waits in the output register while the next sample is taken
module hearing_mix_soft_knee_limiter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] sample_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "hearing_mix_soft_knee_limiter_top_macros.svh"

  // config registers
  logic [15:0] mic_gain_q, amb_gain_q;
  logic        ns_en_q;

  // filter and limiter state
  logic signed [15:0] hp_in_q;
  logic signed [23:0] hp_out_q;
  logic        [23:0] env_q;

  // per-sample working registers
  logic signed [15:0] x_q;
  logic signed [23:0] p_q, mix_q;
  logic signed [40:0] acc_q;
  logic        [12:0] k_q;
  logic        [27:0] num_q;
  logic        [15:0] gain_q;
  logic signed [15:0] y_q, out_q;
  logic               out_valid_q;

  hmskl_pkg::state_e state_q, state_d;

  // shared units
  logic                                 mul_start, div_start;
  logic signed [hmskl_pkg::MUL_A_W-1:0] mul_a;
  logic        [hmskl_pkg::MUL_B_W-1:0] mul_b;
  logic signed [hmskl_pkg::MUL_P_W-1:0] mul_p;
  hmskl_pkg::unit_stat_t                mul_stat, div_stat;
  logic        [hmskl_pkg::DIV_N_W-1:0] div_q;

  logic in_acc, out_free, cfg_wr;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    if (v > 30'sd8388607) return 24'sh7FFFFF;
    if (v < -30'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    if (v > 26'sd32767) return 16'sh7FFF;
    if (v < -26'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  // apb registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mic_gain_q <= hmskl_pkg::MIC_GAIN_RST;
      amb_gain_q <= hmskl_pkg::AMB_GAIN_RST;
      ns_en_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        hmskl_pkg::REG_MIC_GAIN: mic_gain_q <= pwdata[15:0];
        hmskl_pkg::REG_AMB_GAIN: amb_gain_q <= pwdata[15:0];
        hmskl_pkg::REG_NS_EN:    ns_en_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hmskl_pkg::REG_MIC_GAIN: prdata = {16'd0, mic_gain_q};
      hmskl_pkg::REG_AMB_GAIN: prdata = {16'd0, amb_gain_q};
      hmskl_pkg::REG_NS_EN:    prdata = {31'd0, ns_en_q};
      default:                 prdata = '0;
    endcase
  end

  // envelope step inputs: |mix|, gap and attack or release coefficient
  logic [23:0]        abs_mix;
  logic signed [24:0] env_gap;
  logic               rising;
  logic               env_in_knee;

  always_comb begin
    abs_mix     = mix_q[23] ? 24'(-mix_q) : 24'(mix_q);
    env_gap     = $signed({1'b0, abs_mix}) - $signed({1'b0, env_q});
    rising      = abs_mix > env_q;
    env_in_knee = env_q > hmskl_pkg::KNEE_LO && env_q < hmskl_pkg::KNEE_HI;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hmskl_pkg::ST_IDLE:
        if (in_acc) state_d = ns_en_q ? hmskl_pkg::ST_HP_GO : hmskl_pkg::ST_MIX1_GO;
      hmskl_pkg::ST_HP_GO:     state_d = hmskl_pkg::ST_HP_WAIT;
      hmskl_pkg::ST_HP_WAIT:   if (mul_stat.done) state_d = hmskl_pkg::ST_MIX1_GO;
      hmskl_pkg::ST_MIX1_GO:   state_d = hmskl_pkg::ST_MIX1_WAIT;
      hmskl_pkg::ST_MIX1_WAIT: if (mul_stat.done) state_d = hmskl_pkg::ST_MIX2_GO;
      hmskl_pkg::ST_MIX2_GO:   state_d = hmskl_pkg::ST_MIX2_WAIT;
      hmskl_pkg::ST_MIX2_WAIT: if (mul_stat.done) state_d = hmskl_pkg::ST_ENV_GO;
      hmskl_pkg::ST_ENV_GO:    state_d = hmskl_pkg::ST_ENV_WAIT;
      hmskl_pkg::ST_ENV_WAIT:  if (mul_stat.done) state_d = hmskl_pkg::ST_KNEE_CHK;
      hmskl_pkg::ST_KNEE_CHK:
        if (env_q <= hmskl_pkg::KNEE_LO || env_q >= hmskl_pkg::KNEE_HI)
          state_d = hmskl_pkg::ST_OUT;
        else
          state_d = hmskl_pkg::ST_SQ_GO;
      hmskl_pkg::ST_SQ_GO:     state_d = hmskl_pkg::ST_SQ_WAIT;
      hmskl_pkg::ST_SQ_WAIT:   if (mul_stat.done) state_d = hmskl_pkg::ST_DIV_GO;
      hmskl_pkg::ST_DIV_GO:    state_d = hmskl_pkg::ST_DIV_WAIT;
      hmskl_pkg::ST_DIV_WAIT:  if (div_stat.done) state_d = hmskl_pkg::ST_KM_GO;
      hmskl_pkg::ST_KM_GO:     state_d = hmskl_pkg::ST_KM_WAIT;
      hmskl_pkg::ST_KM_WAIT:   if (mul_stat.done) state_d = hmskl_pkg::ST_OUT;
      hmskl_pkg::ST_OUT:       if (out_free) state_d = hmskl_pkg::ST_IDLE;
      default:                 state_d = hmskl_pkg::ST_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    in_stall_o = (state_q != hmskl_pkg::ST_IDLE);
    unique case (state_q)
      hmskl_pkg::ST_HP_GO: begin
        mul_start = 1'b1;
        mul_a     = 25'(hp_out_q);
        mul_b     = hmskl_pkg::HP_POLE;
      end
      hmskl_pkg::ST_MIX1_GO: begin
        mul_start = 1'b1;
        mul_a     = 25'(p_q);
        mul_b     = mic_gain_q;
      end
      hmskl_pkg::ST_MIX2_GO: begin
        mul_start = 1'b1;
        mul_a     = 25'(x_q);
        mul_b     = amb_gain_q;
      end
      hmskl_pkg::ST_ENV_GO: begin
        mul_start = 1'b1;
        mul_a     = env_gap;
        mul_b     = rising ? hmskl_pkg::ATTACK_COEF : hmskl_pkg::RELEASE_COEF;
      end
      hmskl_pkg::ST_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = $signed({12'd0, k_q});
        mul_b     = {3'd0, k_q};
      end
      hmskl_pkg::ST_DIV_GO: div_start = 1'b1;
      hmskl_pkg::ST_KM_GO: begin
        mul_start = 1'b1;
        mul_a     = 25'(mix_q);
        mul_b     = gain_q;
      end
      default: ;
    endcase
  end

  // datapath step results
  logic signed [40:0] hp_rnd, km_rnd;
  logic signed [26:0] hp_sum;
  logic signed [41:0] mix_sum, mix_rnd;
  logic signed [40:0] env_rnd;
  logic signed [25:0] env_new;
  logic        [27:0] sq5;

  always_comb begin
    hp_rnd  = mul_p + 41'sd16384;
    hp_sum  = 27'(x_q) - 27'(hp_in_q) + 27'($signed(hp_rnd[40:15]));
    mix_sum = 42'(acc_q) + 42'(mul_p);
    mix_rnd = mix_sum + 42'sd2048;
    env_rnd = mul_p + 41'sd32768;
    env_new = $signed({2'b00, env_q}) + 26'($signed(env_rnd[40:16]));
    sq5     = {mul_p[25:0], 2'b00} + 28'(mul_p[25:0]) + 28'(env_q);
    km_rnd  = mul_p + 41'sd16384;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hmskl_pkg::ST_IDLE;
      hp_in_q     <= '0;
      hp_out_q    <= '0;
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new result replaces the one leaving in the same cycle
      if (state_q == hmskl_pkg::ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        hmskl_pkg::ST_HP_WAIT:
          if (mul_stat.done) begin
            hp_in_q  <= x_q;
            hp_out_q <= sat24(30'(hp_sum));
          end
        hmskl_pkg::ST_ENV_WAIT:
          if (mul_stat.done) begin
            if (env_new < 0) env_q <= '0;
            else if (env_new > $signed({2'b00, hmskl_pkg::ENV_MAX}))
              env_q <= hmskl_pkg::ENV_MAX;
            else env_q <= env_new[23:0];
          end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      hmskl_pkg::ST_IDLE:
        if (in_acc) begin
          x_q <= sample_in_i;
          p_q <= 24'($signed(sample_in_i));
        end
      hmskl_pkg::ST_HP_WAIT:   if (mul_stat.done) p_q <= sat24(30'(hp_sum));
      hmskl_pkg::ST_MIX1_WAIT: if (mul_stat.done) acc_q <= mul_p;
      hmskl_pkg::ST_MIX2_WAIT: if (mul_stat.done) mix_q <= sat24(mix_rnd[41:12]);
      hmskl_pkg::ST_KNEE_CHK: begin
        k_q <= 13'(env_q - hmskl_pkg::KNEE_LO);
        if (env_q <= hmskl_pkg::KNEE_LO) y_q <= sat16(26'(mix_q));
        else if (mix_q > 0) y_q <= hmskl_pkg::LIMIT_POS;
        else if (mix_q < 0) y_q <= hmskl_pkg::LIMIT_NEG;
        else y_q <= '0;
      end
      hmskl_pkg::ST_SQ_WAIT:   if (mul_stat.done) num_q <= sq5;
      hmskl_pkg::ST_DIV_WAIT:  if (div_stat.done) gain_q <= 16'(17'h08000 - 17'(div_q[15:0]));
      hmskl_pkg::ST_KM_WAIT:   if (mul_stat.done) y_q <= sat16(km_rnd[40:15]);
      hmskl_pkg::ST_OUT:       if (out_free) out_q <= y_q;
      default: ;
    endcase
  end

  hmskl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_p),
    .stat_o  (mul_stat)
  );

  // divisor is twice the envelope, which stays below the upper knee here
  hmskl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   ({env_q[14:0], 1'b0}),
    .quo_o   (div_q),
    .stat_o  (div_stat)
  );

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  `HMSKL_ASSERT(a_mul_idle_start, clk_i, rst_ni, !mul_start || !mul_stat.busy)
  `HMSKL_ASSERT(a_div_idle_start, clk_i, rst_ni, !div_start || !div_stat.busy)
  `HMSKL_ASSERT(a_div_in_knee, clk_i, rst_ni, !div_start || env_in_knee)
  `HMSKL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)

endmodule

// ===== src/hmskl_mul.sv =====
// bit-serial signed x unsigned multiplier, one multiplier bit per cycle
module hmskl_mul (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [hmskl_pkg::MUL_A_W-1:0]   a_i,
  input  logic        [hmskl_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [hmskl_pkg::MUL_P_W-1:0]   prod_o,
  output hmskl_pkg::unit_stat_t                  stat_o
);

  localparam int unsigned CntW = $clog2(hmskl_pkg::MUL_B_W);

  logic signed [hmskl_pkg::MUL_A_W-1:0] a_q;
  logic signed [hmskl_pkg::MUL_A_W:0]   hi_q, hi_d, sum;
  logic        [hmskl_pkg::MUL_B_W-1:0] lo_q, lo_d;
  logic        [CntW-1:0]               cnt_q;
  logic                                 busy_q, done_q;

  always_comb begin
    sum  = hi_q + (lo_q[0] ? {a_q[hmskl_pkg::MUL_A_W-1], a_q} : '0);
    hi_d = {sum[hmskl_pkg::MUL_A_W], sum[hmskl_pkg::MUL_A_W:1]};
    lo_d = {sum[0], lo_q[hmskl_pkg::MUL_B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(hmskl_pkg::MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o      = hmskl_pkg::MUL_P_W'({hi_q, lo_q});
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== src/hmskl_div.sv =====
// restoring divider, one quotient bit per cycle
module hmskl_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [hmskl_pkg::DIV_N_W-1:0]     num_i,
  input  logic [hmskl_pkg::DIV_D_W-1:0]     den_i,
  output logic [hmskl_pkg::DIV_N_W-1:0]     quo_o,
  output hmskl_pkg::unit_stat_t             stat_o
);

  localparam int unsigned CntW = $clog2(hmskl_pkg::DIV_N_W);

  logic [hmskl_pkg::DIV_D_W-1:0] den_q, rem_q;
  logic [hmskl_pkg::DIV_N_W-1:0] quo_q;
  logic [hmskl_pkg::DIV_D_W:0]   sh;
  logic [hmskl_pkg::DIV_D_W+1:0] diff;
  logic                          ge;
  logic [CntW-1:0]               cnt_q;
  logic                          busy_q, done_q;

  always_comb begin
    sh   = {rem_q, quo_q[hmskl_pkg::DIV_N_W-1]};
    diff = {1'b0, sh} - {2'b00, den_q};
    ge   = ~diff[hmskl_pkg::DIV_D_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(hmskl_pkg::DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[hmskl_pkg::DIV_D_W-1:0] : sh[hmskl_pkg::DIV_D_W-1:0];
      quo_q <= {quo_q[hmskl_pkg::DIV_N_W-2:0], ge};
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned RANDOM_ITEMS   = 1600;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] sample_in;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] sample_out;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hearing_mix_soft_knee_limiter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_in_i (sample_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sample_out_o(sample_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // model copy of registers and filter / envelope state
  logic [15:0] mdl_mic_gain;
  logic [15:0] mdl_amb_gain;
  logic        mdl_ns_en;
  longint      mdl_hp_x;
  longint      mdl_hp_y;
  longint      mdl_env;

  logic [15:0] expected_samples[$];
  int unsigned mismatch_count;
  bit          failed;
  int unsigned idle_cycles;
  bit          hold_off_active;
  int unsigned hold_off_len;
  bit          out_quiet;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // floor((v + half) / 2^s)
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // expected limiter output for one sample, advancing model state
  function automatic logic [15:0] limit_sample(logic [15:0] raw);
    longint x, p, mix, a, d, k, ratio, y;
    x = longint'($signed(raw));
    p = x;
    if (mdl_ns_en) begin
      p = x - mdl_hp_x + rnd_shift(mdl_hp_y * longint'(hmskl_pkg::HP_POLE), 15);
      p = clip(p, -8388608, 8388607);
      mdl_hp_x = x;
      mdl_hp_y = p;
    end
    mix = rnd_shift(p * longint'(mdl_mic_gain) + x * longint'(mdl_amb_gain), 12);
    mix = clip(mix, -8388608, 8388607);
    a = mix < 0 ? -mix : mix;
    d = a - mdl_env;
    mdl_env += rnd_shift(d * (a > mdl_env ? longint'(hmskl_pkg::ATTACK_COEF)
                                         : longint'(hmskl_pkg::RELEASE_COEF)), 16);
    mdl_env = clip(mdl_env, 0, 16777215);
    if (mdl_env <= longint'(hmskl_pkg::KNEE_LO)) begin
      y = mix;
    end else if (mdl_env >= longint'(hmskl_pkg::KNEE_HI)) begin
      y = mix > 0 ? 26214 : (mix < 0 ? -26214 : 0);
    end else begin
      k = mdl_env - longint'(hmskl_pkg::KNEE_LO);
      ratio = (5 * k * k + mdl_env) / (2 * mdl_env);
      y = rnd_shift(mix * (32768 - ratio), 15);
    end
    y = clip(y, -32768, 32767);
    return y[15:0];
  endfunction

  // apb write: setup then access phase
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      hmskl_pkg::REG_MIC_GAIN: mdl_mic_gain = value[15:0];
      hmskl_pkg::REG_AMB_GAIN: mdl_amb_gain = value[15:0];
      hmskl_pkg::REG_NS_EN:    mdl_ns_en    = value[0];
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [15:0] mic, logic [15:0] amb, logic ns);
    wait_drained();
    write_reg(hmskl_pkg::REG_MIC_GAIN, {16'h0, mic});
    write_reg(hmskl_pkg::REG_AMB_GAIN, {16'h0, amb});
    write_reg(hmskl_pkg::REG_NS_EN, {31'h0, ns});
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one sample and hold it until it is accepted
  task automatic send_sample(logic [15:0] value, bit use_gaps);
    int unsigned gap;
    gap = use_gaps ? gap_len() : 0;
    repeat (gap + 1) @(negedge clk);
    in_valid  <= 1'b1;
    sample_in <= value;
    expected_samples.push_back(limit_sample(value));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r < 4) return 16'($urandom_range(0, 255)) ^ {16{r[0]}};
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_gain();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'd4096;
    return 16'($urandom_range(0, 16384));
  endfunction

  // extremes of the sample with unity gain, no filter: below and above knee
  task automatic test_directed_passthrough();
    set_gains(16'd4096, 16'd0, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    // push the envelope up with a run of full-scale samples
    repeat (6) send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b0);
  endtask

  // full gains saturate the output, high-pass on and a zero input at the limit
  task automatic test_directed_extremes();
    set_gains(16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    set_gains(16'd0, 16'd0, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h1234, 1'b0);
    // low-level run on the ambient path lets the envelope release
    set_gains(16'd0, 16'd4096, 1'b0);
    repeat (4) send_sample(16'h0100, 1'b0);
  endtask

  // random samples through several register settings
  task automatic test_random_settings();
    int unsigned phase;
    for (phase = 0; phase < 8; phase++) begin
      set_gains(rand_gain(), rand_gain(), 1'($urandom_range(0, 1)));
      repeat (RANDOM_ITEMS / 8) send_sample(rand_sample(), 1'b1);
    end
  endtask

  // receiver holds off while samples keep coming, then sender waits out drain
  task automatic test_backpressure();
    set_gains(16'd4096, 16'd2048, 1'b1);
    hold_off_len    = 1500;
    hold_off_active = 1'b1;
    repeat (12) send_sample(rand_sample(), 1'b0);
    while (hold_off_active) @(posedge clk);
    wait_drained();
    repeat (8) send_sample(rand_sample(), 1'b1);
  endtask

  // receiver stall: random gaps, quiet stretches, forced hold-off
  initial begin
    int unsigned run;
    out_stall <= 1'b1;
    forever begin
      @(negedge clk);
      if (hold_off_active) begin
        out_stall <= 1'b1;
        repeat (hold_off_len) @(negedge clk);
        hold_off_active = 1'b0;
      end else if (out_quiet) begin
        out_stall <= 1'b0;
      end else begin
        run = gap_len();
        if (run != 0) begin
          out_stall <= 1'b1;
          repeat (run) @(negedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    logic [15:0] exp_val;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        failed = 1'b1;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: sample_out %0d", $signed(sample_out));
      end else begin
        exp_val = expected_samples.pop_front();
        if (sample_out !== exp_val) begin
          failed = 1'b1;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("sample_out mismatch: expected %0d actual %0d",
                     $signed(exp_val), $signed(sample_out));
        end
      end
    end
  end

  // watchdog on cycles with no accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    sample_in       = 16'h0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = 4'h0;
    pwdata          = 32'h0;
    mismatch_count  = 0;
    failed          = 1'b0;
    idle_cycles     = 0;
    hold_off_active = 1'b0;
    hold_off_len    = 0;
    out_quiet       = 1'b0;
    mdl_mic_gain    = hmskl_pkg::MIC_GAIN_RST;
    mdl_amb_gain    = hmskl_pkg::AMB_GAIN_RST;
    mdl_ns_en       = 1'b0;
    mdl_hp_x        = 0;
    mdl_hp_y        = 0;
    mdl_env         = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values first, with a receiver that never stalls
    out_quiet = 1'b1;
    send_sample(16'h4000, 1'b0);
    send_sample(16'hC000, 1'b0);
    out_quiet = 1'b0;

    test_directed_passthrough();
    test_directed_extremes();
    test_backpressure();
    test_random_settings();

    wait_drained();
    if (failed || expected_samples.size() != 0) begin
      $display("*** FAILED ***");
    end else begin
      $display("*** PASSED ***");
    end
    $finish;
  end

endmodule
